>>> src/ima_blk_pkg.sv
// Shared types, constants and table functions of the IMA ADPCM block decoder.
`default_nettype none

package ima_blk_pkg;

   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned INDEX_W    = 7;
   localparam int unsigned STEP_W     = 15;
   localparam int unsigned POS_W      = 15;
   localparam int unsigned BWORDS_W   = 14;
   localparam logic [INDEX_W-1:0] INDEX_MAX = 7'd88;
   localparam logic [BWORDS_W-1:0] BWORDS_RESET = 14'd256;
   localparam logic signed [SAMPLE_W+1:0] SAMPLE_MAX = 18'sd32767;
   localparam logic signed [SAMPLE_W+1:0] SAMPLE_MIN = -18'sd32768;

   // Decoder state carried from one nibble to the next
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] predictor;
      logic [INDEX_W-1:0]         step_index;
   } dec_state_type;

   localparam logic [STEP_W-1:0] STEP_SIZES [0:88] = '{
      15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
      15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
      15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
      15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
      15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
      15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
      15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
      15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
      15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
      15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
      15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
      15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
      15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
   };

   // Step size for an index; indexes above the table end read the last entry
   function automatic logic [STEP_W-1:0] step_size(input logic [INDEX_W-1:0] idx);
      logic [INDEX_W-1:0] sel;
      sel = (idx > INDEX_MAX) ? INDEX_MAX : idx;
      return STEP_SIZES[sel];
   endfunction

   // Step index adjustment for a nibble magnitude
   function automatic logic signed [4:0] index_move(input logic [2:0] mag);
      logic signed [4:0] mv;
      case (mag)
         3'd4:    mv = 5'sd2;
         3'd5:    mv = 5'sd4;
         3'd6:    mv = 5'sd6;
         3'd7:    mv = 5'sd8;
         default: mv = -5'sd1;
      endcase
      return mv;
   endfunction

endpackage

`default_nettype wire

>>> src/ima_blk_nibble_dec.sv
// One IMA ADPCM nibble decode step: new predictor and step index from the old state.
`default_nettype none

module ima_blk_nibble_dec
   import ima_blk_pkg::*;
(
   input  wire dec_state_type  cur_state,
   input  wire logic [3:0]     nibble,
   output dec_state_type       next_state
);

   logic [2:0]                 mag;
   logic [STEP_W-1:0]          step;
   logic [STEP_W+4:0]          product;
   logic [SAMPLE_W-1:0]        diff;
   logic signed [SAMPLE_W+1:0] pred_ext;
   logic signed [SAMPLE_W+1:0] diff_ext;
   logic signed [SAMPLE_W+1:0] sum;
   logic signed [4:0]          move;
   logic signed [INDEX_W:0]    move_ext;
   logic signed [INDEX_W:0]    idx_sum;

   assign mag      = nibble[2:0];
   assign step     = step_size(cur_state.step_index);
   assign product  = {16'd0, mag, 1'b1} * {5'd0, step};
   assign diff     = product[SAMPLE_W+2:3];
   assign pred_ext = {{2{cur_state.predictor[SAMPLE_W-1]}}, cur_state.predictor};
   assign diff_ext = {2'b00, diff};
   assign sum      = nibble[3] ? (pred_ext - diff_ext) : (pred_ext + diff_ext);
   assign move     = index_move(mag);
   assign move_ext = {{(INDEX_W-4){move[4]}}, move};
   assign idx_sum  = $signed({1'b0, cur_state.step_index}) + move_ext;

   always_comb begin
      // saturate the predictor to the 16-bit sample range
      if (sum > SAMPLE_MAX) begin
         next_state.predictor = SAMPLE_MAX[SAMPLE_W-1:0];
      end else if (sum < SAMPLE_MIN) begin
         next_state.predictor = SAMPLE_MIN[SAMPLE_W-1:0];
      end else begin
         next_state.predictor = sum[SAMPLE_W-1:0];
      end
      // clamp the step index to the table
      if (idx_sum < 0) begin
         next_state.step_index = '0;
      end else if (idx_sum > $signed({1'b0, INDEX_MAX})) begin
         next_state.step_index = INDEX_MAX;
      end else begin
         next_state.step_index = idx_sum[INDEX_W-1:0];
      end
   end

endmodule

`default_nettype wire

>>> src/ima_adpcm_block_decoder_core.sv
// Top level of the IMA ADPCM block decoder: byte intake, block tracking and result register.
//
// Decodes a mono 4-bit IMA ADPCM byte stream, one byte per req item. The stream
// is cut into blocks of csr block_words 4-byte words (0 reads as 1, values above
// MAX_BLOCK_WORDS read as MAX_BLOCK_WORDS). The first four bytes of a block are
// the header: predictor low byte, predictor high byte, step index (clamped to 88)
// and a spare byte; they give no result item. Every later byte gives two rsp items,
// the low-nibble sample first (tlast low) and then the high-nibble sample (tlast
// high). A header byte leaves the hold stage once it is held; a data byte stays for
// both its nibbles, since the two samples share one nibble decoder and leave through
// one result register at one item per cycle while the register is free. A new byte
// is taken in the same cycle that the held byte finishes, so a run of header bytes
// flows at one byte a cycle. A finished sample waits in the result register for
// rsp_tready; header bytes keep flowing meanwhile, while a held data byte stalls
// until the register frees. Write csr only while idle.
`default_nettype none

module ima_adpcm_block_decoder_core
   import ima_blk_pkg::*;
#(
   parameter int unsigned MAX_BLOCK_WORDS = 8192
)(
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration: block_words
   input  wire logic        csr_wen,
   input  wire logic [13:0] csr_wdata,   // [13:0] block_words
   // byte stream in
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   // samples out
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] sample
   output logic             rsp_tlast    // high on the high-nibble sample
);

   typedef enum logic [2:0] {
      KIND_HDR_PRED_LO,
      KIND_HDR_PRED_HI,
      KIND_HDR_STEP,
      KIND_HDR_SPARE,
      KIND_DATA
   } kind_type;

   localparam logic [16:0] MAX_WORDS = 17'(MAX_BLOCK_WORDS);

   // configuration
   logic [BWORDS_W-1:0] block_words_ff;

   // block position tracking
   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    pos_in;
   logic [POS_W-1:0]    pos_inc;
   logic [16:0]         words_eff;
   logic [18:0]         block_len;
   kind_type            kind_in;

   // hold stage
   logic                hold_valid_ff;
   kind_type            hold_kind_ff;
   logic [7:0]          hold_byte_ff;
   logic                phase_ff;
   logic                hold_done;
   logic                req_fire;

   // decoder state
   dec_state_type       dec_state_ff;
   dec_state_type       dec_next;
   logic [7:0]          hdr_low_ff;
   logic [3:0]          nibble;
   logic                is_data;

   // result register
   logic                out_valid_ff;
   logic [15:0]         out_sample_ff;
   logic                out_last_ff;
   logic                out_load;
   logic                out_free;

   // ------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         block_words_ff <= BWORDS_RESET;
      end else if (csr_wen) begin
         block_words_ff <= csr_wdata;
      end
   end

   // ------------------------------------------------------------------
   // Block position: classify the incoming byte and advance the offset
   // ------------------------------------------------------------------
   always_comb begin
      if (block_words_ff == '0) begin
         words_eff = 17'd1;
      end else if ({3'b000, block_words_ff} > MAX_WORDS) begin
         words_eff = MAX_WORDS;
      end else begin
         words_eff = {3'b000, block_words_ff};
      end
   end

   assign block_len = {words_eff, 2'b00};
   assign pos_inc   = pos_ff + 15'd1;

   always_comb begin
      // wrap back to a header at the block end or when the offset overflows
      if ((pos_inc == '0) || ({4'd0, pos_inc} >= block_len)) begin
         pos_in = '0;
      end else begin
         pos_in = pos_inc;
      end
      case (pos_ff)
         15'd0:   kind_in = KIND_HDR_PRED_LO;
         15'd1:   kind_in = KIND_HDR_PRED_HI;
         15'd2:   kind_in = KIND_HDR_STEP;
         15'd3:   kind_in = KIND_HDR_SPARE;
         default: kind_in = KIND_DATA;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (req_fire) begin
         pos_ff <= pos_in;
      end
   end

   // ------------------------------------------------------------------
   // Hold stage: one byte at a time; a data byte stays for its low, then its high nibble
   // ------------------------------------------------------------------
   assign is_data    = (hold_kind_ff == KIND_DATA);
   assign out_free   = !out_valid_ff || rsp_tready;
   assign out_load   = hold_valid_ff && is_data && out_free;
   assign hold_done  = hold_valid_ff && (!is_data || (phase_ff && out_free));
   assign req_tready = !hold_valid_ff || hold_done;
   assign req_fire   = req_tvalid && req_tready;
   assign nibble     = phase_ff ? hold_byte_ff[7:4] : hold_byte_ff[3:0];

   ima_blk_nibble_dec u_nibble_dec (
      .cur_state  (dec_state_ff),
      .nibble     (nibble),
      .next_state (dec_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
      end else begin
         if (req_fire) begin
            hold_valid_ff <= 1'b1;
            phase_ff      <= 1'b0;
         end else if (hold_done) begin
            hold_valid_ff <= 1'b0;
            phase_ff      <= 1'b0;
         end else if (out_load) begin
            // low nibble gone: advance to the high nibble
            phase_ff <= 1'b1;
         end
      end
      if (req_fire) begin
         hold_kind_ff <= kind_in;
         hold_byte_ff <= req_tdata;
      end
   end

   // Decoder state: header bytes load it, nibbles advance it
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_state_ff <= '0;
         hdr_low_ff   <= '0;
      end else if (hold_valid_ff) begin
         case (hold_kind_ff)
            KIND_HDR_PRED_LO: begin
               hdr_low_ff <= hold_byte_ff;
            end
            KIND_HDR_PRED_HI: begin
               dec_state_ff.predictor <= {hold_byte_ff, hdr_low_ff};
            end
            KIND_HDR_STEP: begin
               dec_state_ff.step_index <= (hold_byte_ff > {1'b0, INDEX_MAX}) ?
                                          INDEX_MAX : hold_byte_ff[INDEX_W-1:0];
            end
            KIND_DATA: begin
               if (out_free) begin
                  dec_state_ff <= dec_next;
               end
            end
            default: begin
               // spare header byte: drop
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (out_load) begin
         out_sample_ff <= dec_next.predictor;
         out_last_ff   <= phase_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sample_ff;
   assign rsp_tlast  = out_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      dec_state_ff.step_index <= INDEX_MAX)
      else $error("step index left the table");

   a_phase_data: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (hold_valid_ff && is_data))
      else $error("high-nibble phase without a held data byte");

   a_low_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && is_data && !phase_ff) |-> !req_tready)
      else $error("byte taken before the held data byte finished");

   a_high_follows_low: assert property (@(posedge clock) disable iff (reset)
      (out_load && phase_ff) |-> (out_valid_ff && !out_last_ff) || $past(out_load))
      else $error("high-nibble sample without its low-nibble sample");

endmodule

`default_nettype wire
